### rtl/core/sdbt_pkg.sv
// Shared types and constants for the strip dirty box tracker.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package sdbt_pkg;
    localparam int SCREEN_WIDTH  = 368;
    localparam int SCREEN_HEIGHT = 448;
    localparam int STRIP_ROWS    = 64;
    localparam int STRIPS        = 7;
    localparam int GATHER_RESET  = 128 * 64;

    localparam int FIELD_W = 12;
    localparam int COORD_W = 9;
    localparam int LIMIT_W = 16;
    localparam int IDX_W   = (STRIPS > 1) ? $clog2(STRIPS) : 1;
    localparam int AREA_W  = 2 * COORD_W;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [STRIPS-1:0]  t_mask;

    typedef enum logic [2:0] {
        ACT_MARK_BOX  = 3'd0,
        ACT_MARK_ROWS = 3'd1,
        ACT_MARK_ALL  = 3'd2,
        ACT_QUERY     = 3'd3,
        ACT_PRESENT   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        KIND_QUERY    = 2'd0,
        KIND_FULL     = 2'd1,
        KIND_GATHERED = 2'd2,
        KIND_NONE     = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // One classified command as it travels from the front to the back.
    typedef struct packed {
        t_action action;
        logic    hit;
        t_coord  x0;
        t_coord  x1;
        t_coord  y0;
        t_coord  y1;
        t_idx    first;
        t_idx    last;
    } t_cmd;
endpackage
`default_nettype wire

### rtl/core/sdbt_front.sv
// Front end: clips an incoming command and finds the strips it touches.
// Depends on sdbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdbt_front
    import sdbt_pkg::*;
(
    input  wire logic [2:0]         i_action,
    input  wire logic [FIELD_W-1:0] i_x_pos,
    input  wire logic [FIELD_W-1:0] i_y_pos,
    input  wire logic [FIELD_W-1:0] i_width_in,
    input  wire logic [FIELD_W-1:0] i_height_in,
    output logic                    o_keep,
    output t_cmd                    o_cmd
);
    logic signed [FIELD_W:0] xs, xe, ys, ye, x0, x1, y0, y1;
    logic                    col_ok, row_ok;
    logic [FIELD_W:0]        first_w, last_w;
    t_idx                    first, last;

    always_comb begin
        xs = (FIELD_W+1)'(signed'(i_x_pos));
        xe = xs + (FIELD_W+1)'(signed'(i_width_in));
        ys = (FIELD_W+1)'(signed'(i_y_pos));
        ye = ys + (FIELD_W+1)'(signed'(i_height_in));
        x0 = (xs < 0) ? '0 : xs;
        x1 = (xe > (FIELD_W+1)'(SCREEN_WIDTH)) ? (FIELD_W+1)'(SCREEN_WIDTH) : xe;
        y0 = (ys < 0) ? '0 : ys;
        y1 = (ye > (FIELD_W+1)'(SCREEN_HEIGHT)) ? (FIELD_W+1)'(SCREEN_HEIGHT) : ye;
        col_ok  = x0 < x1;
        first_w = (FIELD_W+1)'(unsigned'(y0) / STRIP_ROWS);
        last_w  = (FIELD_W+1)'(unsigned'(y1 - (FIELD_W+1)'(1)) / STRIP_ROWS);
        // Rows below the last strip belong to no strip.
        row_ok  = (y0 < y1) && (first_w < (FIELD_W+1)'(STRIPS));
        first   = first_w[IDX_W-1:0];
        last    = (last_w >= (FIELD_W+1)'(STRIPS)) ? IDX_W'(STRIPS - 1)
                                                   : last_w[IDX_W-1:0];

        o_cmd.action = t_action'(i_action);
        o_cmd.x0     = x0[COORD_W-1:0];
        o_cmd.x1     = x1[COORD_W-1:0];
        o_cmd.y0     = y0[COORD_W-1:0];
        o_cmd.y1     = y1[COORD_W-1:0];
        o_cmd.first  = first;
        o_cmd.last   = last;
        o_cmd.hit    = row_ok;
        o_keep       = 1'b0;
        unique case (i_action) inside
            ACT_MARK_BOX: begin
                o_cmd.hit = row_ok && col_ok;
                o_keep    = row_ok && col_ok;
            end
            ACT_MARK_ROWS: o_keep = row_ok;
            ACT_QUERY:     o_keep = 1'b1;
            ACT_MARK_ALL, ACT_PRESENT: begin
                o_cmd.first = '0;
                o_cmd.last  = IDX_W'(STRIPS - 1);
                o_keep      = 1'b1;
            end
            default: o_keep = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

### rtl/core/sdbt_queue.sv
// Two-entry command queue between the front and the back.
// Depends on sdbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdbt_queue
    import sdbt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_cmd
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

### rtl/core/sdbt_back.sv
// Back end: holds the strip flags and boxes and walks one strip per cycle.
// Depends on sdbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdbt_back
    import sdbt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_empty,
    input  wire t_cmd               i_cmd,
    input  wire logic [LIMIT_W-1:0] i_limit,
    output logic                    o_pop,
    output logic                    o_idle,
    output logic                    o_strobe,
    output logic [1:0]              o_kind,
    output logic [COORD_W-1:0]      o_left,
    output logic [COORD_W-1:0]      o_top,
    output logic [COORD_W-1:0]      o_right,
    output logic [COORD_W-1:0]      o_bottom,
    output logic                    o_region_dirty,
    output logic                    o_last
);
    t_state r_state, n_state;
    t_cmd   r_cmd;
    t_idx   r_idx;
    logic   r_any;
    t_mask  r_dirty;
    t_coord r_bl [STRIPS];
    t_coord r_br [STRIPS];
    t_coord r_bt [STRIPS];
    t_coord r_bb [STRIPS];

    logic                  r_strobe, r_rd, r_last;
    t_kind                 r_kind;
    t_coord                r_l, r_t, r_r, r_b;

    logic                  cur, at_end, done, res_v, res_rd, res_last, gathered;
    t_kind                 res_kind;
    t_coord                res_l, res_t, res_r, res_b, st, sb, pt, pb;
    logic signed [COORD_W:0] bw, bh;
    logic [AREA_W-1:0]     area;
    t_mask                 higher;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_empty) n_state = ST_RUN;
            ST_RUN:  if (done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        o_idle = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_pop  = !i_empty;
                o_idle = i_empty;
            end
            ST_RUN:  o_pop = 1'b0;
            default: o_pop = 1'b0;
        endcase
    end

    always_comb begin
        cur    = r_dirty[r_idx];
        at_end = r_idx == r_cmd.last;
        st     = COORD_W'(r_idx) * COORD_W'(STRIP_ROWS);
        sb     = st + COORD_W'(STRIP_ROWS);
        pt     = (r_cmd.y0 > st) ? r_cmd.y0 : st;
        pb     = (r_cmd.y1 < sb) ? r_cmd.y1 : sb;
        bw     = signed'({1'b0, r_br[r_idx]}) - signed'({1'b0, r_bl[r_idx]});
        bh     = signed'({1'b0, r_bb[r_idx]}) - signed'({1'b0, r_bt[r_idx]});
        area   = AREA_W'(bw[COORD_W-1:0]) * AREA_W'(bh[COORD_W-1:0]);
        gathered = (bw > 0) && (bh > 0) && (area <= AREA_W'(i_limit));
        // Dirty strips beyond this one decide whether this transfer is the last.
        higher = r_dirty & ~((t_mask'(2) << r_idx) - t_mask'(1));

        done     = at_end;
        res_v    = 1'b0;
        res_kind = KIND_QUERY;
        res_l    = '0;
        res_t    = '0;
        res_r    = '0;
        res_b    = '0;
        res_rd   = 1'b0;
        res_last = 1'b1;
        case (r_cmd.action)
            ACT_QUERY: begin
                if (!r_cmd.hit) begin
                    done  = 1'b1;
                    res_v = 1'b1;
                end else begin
                    res_v  = at_end;
                    res_rd = r_any | cur;
                end
            end
            ACT_PRESENT: begin
                if (cur) begin
                    res_v    = 1'b1;
                    res_last = higher == '0;
                    if (gathered) begin
                        res_kind = KIND_GATHERED;
                        res_l    = r_bl[r_idx];
                        res_t    = r_bt[r_idx];
                        res_r    = r_br[r_idx];
                        res_b    = r_bb[r_idx];
                    end else begin
                        res_kind = KIND_FULL;
                        res_t    = st;
                        res_r    = COORD_W'(SCREEN_WIDTH);
                        res_b    = sb;
                    end
                end else if (at_end && !r_any) begin
                    res_v    = 1'b1;
                    res_kind = KIND_NONE;
                end
            end
            default: res_v = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_dirty  <= '1;
            r_idx    <= '0;
            r_any    <= 1'b0;
            for (int i = 0; i < STRIPS; i++) begin
                r_bl[i] <= '0;
                r_br[i] <= COORD_W'(SCREEN_WIDTH);
                r_bt[i] <= COORD_W'(i * STRIP_ROWS);
                r_bb[i] <= COORD_W'((i + 1) * STRIP_ROWS);
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_RUN) && res_v;
            if (o_pop) begin
                r_cmd <= i_cmd;
                r_idx <= i_cmd.first;
                r_any <= 1'b0;
            end else if (r_state == ST_RUN) begin
                r_idx <= r_idx + IDX_W'(1);
                case (r_cmd.action) inside
                    ACT_MARK_BOX: begin
                        r_dirty[r_idx] <= 1'b1;
                        if (r_cmd.x0 < r_bl[r_idx]) r_bl[r_idx] <= r_cmd.x0;
                        if (r_cmd.x1 > r_br[r_idx]) r_br[r_idx] <= r_cmd.x1;
                        if (pt < r_bt[r_idx])       r_bt[r_idx] <= pt;
                        if (pb > r_bb[r_idx])       r_bb[r_idx] <= pb;
                    end
                    ACT_MARK_ROWS, ACT_MARK_ALL: begin
                        r_dirty[r_idx] <= 1'b1;
                        r_bl[r_idx]    <= '0;
                        r_br[r_idx]    <= COORD_W'(SCREEN_WIDTH);
                        r_bt[r_idx]    <= st;
                        r_bb[r_idx]    <= sb;
                    end
                    ACT_QUERY: r_any <= r_any | cur;
                    ACT_PRESENT: begin
                        if (cur) begin
                            r_any          <= 1'b1;
                            r_dirty[r_idx] <= 1'b0;
                            r_bl[r_idx]    <= COORD_W'(SCREEN_WIDTH);
                            r_br[r_idx]    <= '0;
                            r_bt[r_idx]    <= sb;
                            r_bb[r_idx]    <= st;
                        end
                    end
                    default: r_any <= r_any;
                endcase
            end
        end
        r_kind <= res_kind;
        r_l    <= res_l;
        r_t    <= res_t;
        r_r    <= res_r;
        r_b    <= res_b;
        r_rd   <= res_rd;
        r_last <= res_last;
    end

    assign o_strobe       = r_strobe;
    assign o_kind         = r_kind;
    assign o_left         = r_l;
    assign o_top          = r_t;
    assign o_right        = r_r;
    assign o_bottom       = r_b;
    assign o_region_dirty = r_rd;
    assign o_last         = r_last;
endmodule
`default_nettype wire

### rtl/core/strip_dirty_box_tracker_unit.sv
// Top level of the strip dirty box tracker: front, command queue and back.
// Depends on sdbt_pkg, sdbt_front, sdbt_queue and sdbt_back.
//
//  Channel   Handshake                 Payload
//  command   start / busy              i_action, i_x_pos, i_y_pos, i_width_in, i_height_in
//  config    i_cfg_valid / o_cfg_ready i_cfg_data (gather_limit)
//  result    o_strobe (no stall)       o_kind, o_left, o_top, o_right, o_bottom,
//                                      o_region_dirty, o_last
//
// A command is classified on arrival and queued (two entries) unless it is a
// mark touching no strip or unknown; busy is high while the queue is full. The
// back dequeues a command, then walks one strip per cycle; a present gives at
// most one transfer per cycle. Results are registered and show in the cycle
// after their strip. Reset is synchronous and leaves every strip marked whole.
`timescale 1ns / 1ps
`default_nettype none
module strip_dirty_box_tracker_unit
    import sdbt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_action,
    input  wire logic [FIELD_W-1:0] i_x_pos,
    input  wire logic [FIELD_W-1:0] i_y_pos,
    input  wire logic [FIELD_W-1:0] i_width_in,
    input  wire logic [FIELD_W-1:0] i_height_in,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [LIMIT_W-1:0] i_cfg_data,
    output logic                    o_strobe,
    output logic [1:0]              o_kind,
    output logic [COORD_W-1:0]      o_left,
    output logic [COORD_W-1:0]      o_top,
    output logic [COORD_W-1:0]      o_right,
    output logic [COORD_W-1:0]      o_bottom,
    output logic                    o_region_dirty,
    output logic                    o_last
);
    logic               keep, full, empty, pop, back_idle;
    t_cmd               f_cmd, q_cmd;
    logic [LIMIT_W-1:0] r_limit;

    assign busy        = full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_W'(GATHER_RESET);
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    sdbt_front u_front (
        .i_action    (i_action),
        .i_x_pos     (i_x_pos),
        .i_y_pos     (i_y_pos),
        .i_width_in  (i_width_in),
        .i_height_in (i_height_in),
        .o_keep      (keep),
        .o_cmd       (f_cmd)
    );

    sdbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !full && keep),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (q_cmd)
    );

    sdbt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_cmd          (q_cmd),
        .i_limit        (r_limit),
        .o_pop          (pop),
        .o_idle         (back_idle),
        .o_strobe       (o_strobe),
        .o_kind         (o_kind),
        .o_left         (o_left),
        .o_top          (o_top),
        .o_right        (o_right),
        .o_bottom       (o_bottom),
        .o_region_dirty (o_region_dirty),
        .o_last         (o_last)
    );

`ifndef SYNTHESIS
    a_query_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_kind == KIND_QUERY |-> o_last && o_right == '0)
        else $error("query answer not a single final result");
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_kind == KIND_NONE |-> o_last && !o_region_dirty)
        else $error("empty present result malformed");
    a_xfer_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == KIND_FULL || o_kind == KIND_GATHERED)
        |-> !o_region_dirty && o_right > o_left && o_bottom > o_top)
        else $error("transfer rectangle empty");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_idle && empty |=> !o_strobe)
        else $error("result while idle");
`endif
endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for strip_dirty_box_tracker_unit: directed table, then random commands.
// Depends on sdbt_pkg and the tracker RTL; results are checked against an in-bench predictor.
`timescale 1ns / 1ps
module tb;
    import sdbt_pkg::*;

    typedef struct {
        logic [1:0] kind;
        t_coord     left;
        t_coord     top;
        t_coord     right;
        t_coord     bottom;
        logic       region_dirty;
        logic       last;
    } t_result;

    typedef struct {
        logic [2:0]         action;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] w;
        logic [FIELD_W-1:0] h;
        logic               typed;   // expected result given in the row
        t_result            res;
    } t_row;

    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_action = '0;
    logic [FIELD_W-1:0] i_x_pos = '0, i_y_pos = '0, i_width_in = '0, i_height_in = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [LIMIT_W-1:0] i_cfg_data = '0;
    logic               o_strobe;
    logic [1:0]         o_kind;
    logic [COORD_W-1:0] o_left, o_top, o_right, o_bottom;
    logic               o_region_dirty, o_last;

    strip_dirty_box_tracker_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_x_pos(i_x_pos), .i_y_pos(i_y_pos),
        .i_width_in(i_width_in), .i_height_in(i_height_in),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_kind(o_kind), .o_left(o_left), .o_top(o_top),
        .o_right(o_right), .o_bottom(o_bottom), .o_region_dirty(o_region_dirty),
        .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    int          gather_lim;
    logic [STRIPS-1:0] pred_dirty;
    int          bx_l[STRIPS], bx_r[STRIPS], bx_t[STRIPS], bx_b[STRIPS];
    t_result     pending_results[$];
    int          mismatches = 0;
    int          cycles = 0;

    function automatic int sext(logic [FIELD_W-1:0] v);
        return int'(signed'(v));
    endfunction

    function automatic void claim_strip(int i);
        pred_dirty[i] = 1'b1;
        bx_l[i] = 0;
        bx_r[i] = SCREEN_WIDTH;
        bx_t[i] = i * STRIP_ROWS;
        bx_b[i] = (i + 1) * STRIP_ROWS;
    endfunction

    function automatic bit clip_rows(int y, int h, output int y0, output int y1,
                                     output int s0, output int s1);
        y0 = (y < 0) ? 0 : y;
        y1 = (y + h > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y + h;
        s0 = 0;
        s1 = 0;
        if (y0 >= y1) return 1'b0;
        s0 = y0 / STRIP_ROWS;
        s1 = (y1 - 1) / STRIP_ROWS;
        if (s0 >= STRIPS) return 1'b0;
        if (s1 >= STRIPS) s1 = STRIPS - 1;
        return 1'b1;
    endfunction

    function automatic void predict_command(logic [2:0] act, logic [FIELD_W-1:0] xf,
                                            logic [FIELD_W-1:0] yf, logic [FIELD_W-1:0] wf,
                                            logic [FIELD_W-1:0] hf);
        int x, y, w, h, x0, x1, y0, y1, s0, s1, pt, pb, n, bw, bh;
        bit hit;
        t_result r;
        x = sext(xf);
        y = sext(yf);
        w = sext(wf);
        h = sext(hf);
        r = '{default: '0};
        case (act)
            ACT_MARK_BOX: begin
                x0 = (x < 0) ? 0 : x;
                x1 = (x + w > SCREEN_WIDTH) ? SCREEN_WIDTH : x + w;
                if (x0 < x1 && clip_rows(y, h, y0, y1, s0, s1)) begin
                    for (int i = s0; i <= s1; i++) begin
                        pt = (y0 > i * STRIP_ROWS) ? y0 : i * STRIP_ROWS;
                        pb = (y1 < (i + 1) * STRIP_ROWS) ? y1 : (i + 1) * STRIP_ROWS;
                        pred_dirty[i] = 1'b1;
                        if (x0 < bx_l[i]) bx_l[i] = x0;
                        if (x1 > bx_r[i]) bx_r[i] = x1;
                        if (pt < bx_t[i]) bx_t[i] = pt;
                        if (pb > bx_b[i]) bx_b[i] = pb;
                    end
                end
            end
            ACT_MARK_ROWS: begin
                if (clip_rows(y, h, y0, y1, s0, s1))
                    for (int i = s0; i <= s1; i++) claim_strip(i);
            end
            ACT_MARK_ALL: begin
                for (int i = 0; i < STRIPS; i++) claim_strip(i);
            end
            ACT_QUERY: begin
                r.kind = KIND_QUERY;
                r.last = 1'b1;
                hit = clip_rows(y, h, y0, y1, s0, s1);
                if (hit)
                    for (int i = s0; i <= s1; i++)
                        if (pred_dirty[i]) r.region_dirty = 1'b1;
                pending_results.push_back(r);
            end
            ACT_PRESENT: begin
                n = 0;
                for (int i = 0; i < STRIPS; i++) begin
                    if (pred_dirty[i]) begin
                        bw = bx_r[i] - bx_l[i];
                        bh = bx_b[i] - bx_t[i];
                        r = '{default: '0};
                        if (bw <= 0 || bh <= 0 || bw * bh > gather_lim) begin
                            r.kind = KIND_FULL;
                            r.top = COORD_W'(i * STRIP_ROWS);
                            r.right = COORD_W'(SCREEN_WIDTH);
                            r.bottom = COORD_W'((i + 1) * STRIP_ROWS);
                        end else begin
                            r.kind = KIND_GATHERED;
                            r.left = COORD_W'(bx_l[i]);
                            r.top = COORD_W'(bx_t[i]);
                            r.right = COORD_W'(bx_r[i]);
                            r.bottom = COORD_W'(bx_b[i]);
                        end
                        pending_results.push_back(r);
                        n++;
                        bx_l[i] = SCREEN_WIDTH;
                        bx_r[i] = 0;
                        bx_t[i] = (i + 1) * STRIP_ROWS;
                        bx_b[i] = i * STRIP_ROWS;
                    end
                end
                pred_dirty = '0;
                if (n == 0) begin
                    r = '{default: '0};
                    r.kind = KIND_NONE;
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end else begin
                    pending_results[$].last = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // Result checker: the block cannot be stalled, so every strobe is checked against the next predicted result.
    always @(posedge i_clk) begin
        t_result e;
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d", o_kind);
                mismatches++;
            end else begin
                e = pending_results.pop_front();
                if (o_kind !== e.kind) begin
                    $error("kind: expected %0d, actual %0d", e.kind, o_kind); mismatches++;
                end
                if (o_left !== e.left) begin
                    $error("left: expected %0d, actual %0d", e.left, o_left); mismatches++;
                end
                if (o_top !== e.top) begin
                    $error("top: expected %0d, actual %0d", e.top, o_top); mismatches++;
                end
                if (o_right !== e.right) begin
                    $error("right: expected %0d, actual %0d", e.right, o_right); mismatches++;
                end
                if (o_bottom !== e.bottom) begin
                    $error("bottom: expected %0d, actual %0d", e.bottom, o_bottom);
                    mismatches++;
                end
                if (o_region_dirty !== e.region_dirty) begin
                    $error("region_dirty: expected %0d, actual %0d", e.region_dirty,
                           o_region_dirty);
                    mismatches++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, actual %0d", e.last, o_last); mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Start stays high into the next command when there is no gap between them.
    task automatic send_command(logic [2:0] act, logic [FIELD_W-1:0] xf,
                                logic [FIELD_W-1:0] yf, logic [FIELD_W-1:0] wf,
                                logic [FIELD_W-1:0] hf);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= act;
        i_x_pos <= xf;
        i_y_pos <= yf;
        i_width_in <= wf;
        i_height_in <= hf;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_command(act, xf, yf, wf, hf);
    endtask

    // Waits for every expected result to arrive; marks give no result, so allow the walk to finish.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        gather_lim = int'(val);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [FIELD_W-1:0] coord_val(int hi);
        case ($urandom_range(0, 9))
            0: return FIELD_W'($urandom);
            1: return 12'h800;
            2: return 12'h7FF;
            default: return FIELD_W'($urandom_range(0, hi));
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] span_val();
        case ($urandom_range(0, 9))
            0: return FIELD_W'($urandom);
            1: return FIELD_W'(-$urandom_range(0, 40));
            2: return FIELD_W'($urandom_range(100, 500));
            default: return FIELD_W'($urandom_range(1, 80));
        endcase
    endfunction

    t_row dir_rows[] = '{
        // After reset every strip is whole, so present gives seven full transfers.
        '{ACT_QUERY, 0, 0, 0, 448, 1, '{KIND_QUERY, 0, 0, 0, 0, 1, 1}},
        '{ACT_PRESENT, 0, 0, 0, 0, 0, '{default: '0}},
        '{ACT_PRESENT, 0, 0, 0, 0, 1, '{KIND_NONE, 0, 0, 0, 0, 0, 1}},
        '{ACT_QUERY, 0, 0, 0, 448, 1, '{KIND_QUERY, 0, 0, 0, 0, 0, 1}},
        '{ACT_QUERY, 0, 12'h800, 0, 12'h7FF, 1, '{KIND_QUERY, 0, 0, 0, 0, 0, 1}},
        '{ACT_MARK_BOX, 10, 70, 20, 30, 0, '{default: '0}},
        '{ACT_QUERY, 0, 100, 0, 12'hFF0, 1, '{KIND_QUERY, 0, 0, 0, 0, 0, 1}},
        '{ACT_QUERY, 0, 64, 0, 1, 1, '{KIND_QUERY, 0, 0, 0, 0, 1, 1}},
        '{ACT_PRESENT, 0, 0, 0, 0, 1, '{KIND_GATHERED, 10, 70, 30, 100, 0, 1}},
        '{ACT_MARK_BOX, 12'h800, 12'h800, 12'h7FF, 12'h7FF, 0, '{default: '0}},
        '{ACT_PRESENT, 0, 0, 0, 0, 0, '{default: '0}},
        '{ACT_MARK_BOX, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 0, '{default: '0}},
        '{ACT_MARK_BOX, 0, 0, 0, 10, 0, '{default: '0}},
        '{ACT_MARK_BOX, 0, 447, 5, 1, 0, '{default: '0}},
        '{ACT_MARK_ROWS, 0, 440, 0, 8, 0, '{default: '0}},
        '{ACT_PRESENT, 0, 0, 0, 0, 1, '{KIND_FULL, 0, 384, 368, 448, 0, 1}},
        '{ACT_MARK_ROWS, 0, 12'hFF0, 0, 20, 0, '{default: '0}},
        '{3'd5, 0, 0, 0, 0, 0, '{default: '0}},
        '{3'd6, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 0, '{default: '0}},
        '{3'd7, 0, 0, 0, 0, 0, '{default: '0}},
        '{ACT_MARK_BOX, 0, 130, 367, 10, 0, '{default: '0}},
        '{ACT_MARK_ALL, 0, 0, 0, 0, 0, '{default: '0}},
        '{ACT_QUERY, 0, 447, 0, 1, 1, '{KIND_QUERY, 0, 0, 0, 0, 1, 1}},
        '{ACT_PRESENT, 0, 0, 0, 0, 0, '{default: '0}}
    };

    initial begin
        logic [2:0] act;
        int         pick;
        gather_lim = GATHER_RESET;
        pred_dirty = '0;
        for (int i = 0; i < STRIPS; i++) claim_strip(i);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_command(dir_rows[k].action, dir_rows[k].x, dir_rows[k].y,
                         dir_rows[k].w, dir_rows[k].h);
            // Rows with a typed result replace the predicted one.
            if (dir_rows[k].typed) pending_results[$] = dir_rows[k].res;
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_limit(16'd0);
                1: write_limit(16'hFFFF);
                2: write_limit(16'd500);
                3: write_limit(16'd4096);
                4: write_limit(16'd30000);
                default: write_limit(16'(GATHER_RESET));
            endcase
            for (int n = 0; n < 80; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) act = ACT_MARK_BOX;
                else if (pick < 55) act = ACT_MARK_ROWS;
                else if (pick < 58) act = ACT_MARK_ALL;
                else if (pick < 75) act = ACT_QUERY;
                else if (pick < 95) act = ACT_PRESENT;
                else act = 3'($urandom_range(5, 7));
                send_command(act, coord_val(380), coord_val(460), span_val(), span_val());
            end
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/core/sdbt_pkg.sv
rtl/core/sdbt_front.sv
rtl/core/sdbt_queue.sv
rtl/core/sdbt_back.sv
rtl/core/strip_dirty_box_tracker_unit.sv
tb/tb.sv
